// ----- hdl/key_value_table_core_macros.svh -----
// ----------------------------------------------------------------------------
// Key/value table core assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef KEY_VALUE_TABLE_CORE_MACROS_SVH
`define KEY_VALUE_TABLE_CORE_MACROS_SVH

// Assertion sampled on the rising clock, muted while reset is high.
`define KVT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that also holds during reset.
`define KVT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/kvt_pkg.sv -----
// ----------------------------------------------------------------------------
// Key/value table package
// Sizes, operation codes, cell command type and output formatting helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package kvt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

   localparam int KIND_W  = 2;
   localparam int KEY_W   = 64;
   localparam int VALUE_W = 64;
   localparam int POS_W   = 4;
   localparam int ENTRY_W = 5;

   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SET    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic load_key;
      logic load_value;
      logic shift;
   } cell_cmd_type;

   function automatic logic [POS_W-1:0] pos_out(input logic [IDX_W-1:0] idx);
      logic [31:0] wide;
      wide = 32'(idx);
      return wide[POS_W-1:0];
   endfunction

   function automatic logic [ENTRY_W-1:0] count_out(input logic [COUNT_W-1:0] cnt);
      logic [31:0] wide;
      wide = 32'(cnt);
      return wide[ENTRY_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- hdl/kvt_ifs.sv -----
// ----------------------------------------------------------------------------
// Key/value table channels
// Request and response valid/ready channels with their payloads.
// ----------------------------------------------------------------------------
`default_nettype none

interface kvt_req_if import kvt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [KEY_W-1:0]   key;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output kind, output key, output value, input ready);
   modport sink   (input valid, input kind, input key, input value, output ready);
endinterface

interface kvt_rsp_if import kvt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               found;
   logic [POS_W-1:0]   position;
   logic [VALUE_W-1:0] read_value;
   logic [ENTRY_W-1:0] entry_count;
   logic               status;

   modport source (output valid, output found, output position, output read_value,
                   output entry_count, output status, input ready);
   modport sink   (input valid, input found, input position, input read_value,
                   input entry_count, input status, output ready);
endinterface

`default_nettype wire

// ----- hdl/kvt_cell.sv -----
// ----------------------------------------------------------------------------
// Key/value table cell
// Holds one pair, compares its key, loads or takes its upper neighbor's pair.
// ----------------------------------------------------------------------------
`default_nettype none

module kvt_cell import kvt_pkg::*; (
   input  wire logic               clock,
   input  wire cell_cmd_type       cmd,
   input  wire logic               occupied,
   input  wire logic [KEY_W-1:0]   op_key,
   input  wire logic [VALUE_W-1:0] op_value,
   input  wire logic [KEY_W-1:0]   up_key,
   input  wire logic [VALUE_W-1:0] up_value,
   output logic                    match,
   output logic [KEY_W-1:0]        key,
   output logic [VALUE_W-1:0]      value
);

   logic [KEY_W-1:0]   key_ff;
   logic [VALUE_W-1:0] value_ff;

   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         key_ff   <= up_key;
         value_ff <= up_value;
      end else begin
         if (cmd.load_key) begin
            key_ff <= op_key;
         end
         if (cmd.load_value) begin
            value_ff <= op_value;
         end
      end
   end

   assign match = occupied && (key_ff == op_key);
   assign key   = key_ff;
   assign value = value_ff;

endmodule

`default_nettype wire

// ----- hdl/key_value_table_core.sv -----
// ----------------------------------------------------------------------------
// Key/value table core
// Insertion-ordered table of 64-bit key/value pairs held in a row of cells.
// ----------------------------------------------------------------------------
// Flow: the request is latched when accepted, and the response register is
//   loaded when execute finishes. One item at a time: accepted in idle, then
//   execute, where all cells compare in parallel and the row shifts or loads.
// A full response register that is not taken holds the item in execute.
// Reset: the pair count and handshake state clear at once; the stored pairs
//   are not cleared, there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module key_value_table_core import kvt_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   kvt_req_if.sink    req_ch,
   kvt_rsp_if.source  rsp_ch
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;

   // latched request
   logic [KIND_W-1:0]  op_kind_ff;
   logic [KEY_W-1:0]   op_key_ff;
   logic [VALUE_W-1:0] op_value_ff;

   logic [COUNT_W-1:0] count_ff, count_in;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff;
   logic [POS_W-1:0]   rsp_pos_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic [ENTRY_W-1:0] rsp_count_ff;
   logic               rsp_status_ff;

   // cell row taps
   cell_cmd_type       cell_cmd   [TABLE_DEPTH];
   logic               cell_occ   [TABLE_DEPTH];
   logic               cell_match [TABLE_DEPTH];
   logic [KEY_W-1:0]   cell_key   [TABLE_DEPTH];
   logic [VALUE_W-1:0] cell_value [TABLE_DEPTH];

   logic               req_take;
   logic               commit;
   logic [TABLE_DEPTH-1:0] hit_vec;
   logic               hit;
   logic [IDX_W-1:0]   sel_pos;
   logic [VALUE_W-1:0] sel_value;
   logic               has_room;
   logic               status;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;

   // execute finishes once the response register is free or being emptied
   assign commit = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ch.ready);

   // ---------------------------------------------------------------------
   // Cell row. Cell i holds the pair at position i; occupied below count.
   // On remove the cells at and above the match take their upper neighbor.
   // ---------------------------------------------------------------------
   for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      localparam int UP = (gi < TABLE_DEPTH - 1) ? gi + 1 : gi;

      assign cell_occ[gi] = (COUNT_W'(gi) < count_ff);

      kvt_cell u_cell (
         .clock    (clock),
         .cmd      (cell_cmd[gi]),
         .occupied (cell_occ[gi]),
         .op_key   (op_key_ff),
         .op_value (op_value_ff),
         .up_key   (cell_key[UP]),
         .up_value (cell_value[UP]),
         .match    (cell_match[gi]),
         .key      (cell_key[gi]),
         .value    (cell_value[gi])
      );
   end

   // Keys are unique in the row (set only appends an absent key), so at
   // most one cell hits and the selects reduce to an OR of gated taps.
   always_comb begin
      sel_pos   = '0;
      sel_value = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         hit_vec[i] = cell_match[i] && (op_kind_ff != KIND_CLEAR);
         if (hit_vec[i]) begin
            sel_pos   = sel_pos | IDX_W'(i);
            sel_value = sel_value | cell_value[i];
         end
      end
      hit = |hit_vec;
   end

   assign has_room = (count_ff < COUNT_W'(TABLE_DEPTH));

   // per-cell commands and next count
   always_comb begin
      count_in = count_ff;
      status   = STATUS_DONE;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         cell_cmd[i] = '0;
      end
      if (commit) begin
         case (op_kind_ff)
            KIND_SET: begin
               if (hit) begin
                  for (int i = 0; i < TABLE_DEPTH; i++) begin
                     cell_cmd[i].load_value = hit_vec[i];
                  end
               end else if (has_room) begin
                  for (int i = 0; i < TABLE_DEPTH; i++) begin
                     cell_cmd[i].load_key   = (COUNT_W'(i) == count_ff);
                     cell_cmd[i].load_value = (COUNT_W'(i) == count_ff);
                  end
                  count_in = count_ff + COUNT_W'(1);
               end else begin
                  status = STATUS_FULL;
               end
            end
            KIND_REMOVE: begin
               if (hit) begin
                  for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
                     cell_cmd[i].shift = (IDX_W'(i) >= sel_pos);
                  end
                  count_in = count_ff - COUNT_W'(1);
               end
            end
            KIND_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_kind_ff  <= req_ch.kind;
         op_key_ff   <= req_ch.key;
         op_value_ff <= req_ch.value;
      end
      if (commit) begin
         rsp_found_ff  <= hit;
         rsp_pos_ff    <= pos_out(sel_pos);
         rsp_value_ff  <= sel_value;
         rsp_count_ff  <= count_out(count_in);
         rsp_status_ff <= status;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.found       = rsp_found_ff;
   assign rsp_ch.position    = rsp_pos_ff;
   assign rsp_ch.read_value  = rsp_value_ff;
   assign rsp_ch.entry_count = rsp_count_ff;
   assign rsp_ch.status      = rsp_status_ff;

endmodule

`default_nettype wire

// ----- hdl/kvt_checker.sv -----
// ----------------------------------------------------------------------------
// Key/value table checker
// Port-level assertions on the table core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "key_value_table_core_macros.svh"

module kvt_checker import kvt_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic               rsp_found,
   input wire logic [POS_W-1:0]   rsp_position,
   input wire logic [VALUE_W-1:0] rsp_read_value,
   input wire logic               rsp_status
);

   logic req_take;
   logic rsp_stall;
   logic rsp_miss;
   logic rsp_full;
   logic miss_zero;

   assign req_take  = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_miss  = rsp_valid && !rsp_found;
   assign rsp_full  = rsp_valid && rsp_status;
   assign miss_zero = (rsp_position == '0) && (rsp_read_value == '0);

   // one item in flight: no new item the cycle after one is taken
   `KVT_ASSERT(a_one_in_flight, clock, reset, req_take |=> !req_ready, "item taken while busy")

   // a pending response stays until taken
   `KVT_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid, "response dropped")

   // absent key reports zero position and value
   `KVT_ASSERT(a_miss_zero, clock, reset, rsp_miss |-> miss_zero, "miss with nonzero payload")

   // a refused set never reports a hit
   `KVT_ASSERT(a_full_no_hit, clock, reset, rsp_full |-> !rsp_found, "full status with hit")

endmodule

bind key_value_table_core kvt_checker u_kvt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_found      (rsp_ch.found),
   .rsp_position   (rsp_ch.position),
   .rsp_read_value (rsp_ch.read_value),
   .rsp_status     (rsp_ch.status)
);

`default_nettype wire
